@@ rtl/core/phr_pkg.sv @@
package phr_pkg;

  // Hue sectors of the six-sector HSV table, 60 degrees each
  typedef enum logic [2:0] {
    SECT_RY = 3'd0,
    SECT_YG = 3'd1,
    SECT_GC = 3'd2,
    SECT_CB = 3'd3,
    SECT_BM = 3'd4,
    SECT_MR = 3'd5
  } sector_e;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned HueW     = 9;
  localparam int unsigned OffW     = 6;               // k = hue mod 60
  localparam int unsigned ProdW    = ChanW + OffW;    // d * k
  localparam int unsigned ScaledW  = 29;              // d * k * RecipMul

  localparam logic [HueW-1:0] HueWrap    = 9'd360;
  localparam logic [HueW-1:0] SectorSpan = 9'd60;

  // floor(p / 60) == (p * 17477) >> 20 for every p up to 255 * 59
  localparam logic [ScaledW-1:0] RecipMul   = 29'd17477;
  localparam int unsigned        RecipShift = 20;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    sector_e         sector;
    logic [OffW-1:0] k;
  } hue_t;

  typedef struct packed {
    logic [ChanW-1:0] hi;
    logic [ChanW-1:0] lo;
    logic [ProdW-1:0] prod;
  } spread_t;

  typedef struct packed {
    logic [ChanW-1:0] hi;
    logic [ChanW-1:0] lo;
    logic [ChanW-1:0] m;
  } level_t;

  // Split a hue in degrees into sector and offset; values past 359 wrap once
  function automatic hue_t hue_split(logic [HueW-1:0] hue);
    logic [HueW-1:0] h;
    logic [HueW-1:0] base;
    hue_t            res;
    h = (hue >= HueWrap) ? hue - HueWrap : hue;
    if (h < SectorSpan) begin
      res.sector = SECT_RY;
      base       = '0;
    end else if (h < 9'(2 * SectorSpan)) begin
      res.sector = SECT_YG;
      base       = SectorSpan;
    end else if (h < 9'(3 * SectorSpan)) begin
      res.sector = SECT_GC;
      base       = 9'(2 * SectorSpan);
    end else if (h < 9'(4 * SectorSpan)) begin
      res.sector = SECT_CB;
      base       = 9'(3 * SectorSpan);
    end else if (h < 9'(5 * SectorSpan)) begin
      res.sector = SECT_BM;
      base       = 9'(4 * SectorSpan);
    end else begin
      res.sector = SECT_MR;
      base       = 9'(5 * SectorSpan);
    end
    res.k = OffW'(h - base);
    return res;
  endfunction

endpackage

@@ rtl/core/phr_hue_cfg.sv @@
module phr_hue_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [phr_pkg::HueW-1:0]   cfg_wdata_i,
  output phr_pkg::hue_t              hue_o
);

  phr_pkg::hue_t hue_d, hue_q;

  // Decode once at write time so the pixel path sees sector and offset only
  assign hue_d = cfg_we_i ? phr_pkg::hue_split(cfg_wdata_i) : hue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q <= '{sector: phr_pkg::SECT_RY, k: '0};
    end else begin
      hue_q <= hue_d;
    end
  end

  assign hue_o = hue_q;

endmodule

@@ rtl/core/phr_spread.sv @@
module phr_spread (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  phr_pkg::pixel_t            pix_i,
  input  logic [phr_pkg::OffW-1:0]   k_i,
  input  logic                       next_rdy_i,
  output logic                       rdy_o,
  output logic                       valid_o,
  output phr_pkg::spread_t           spread_o
);

  logic                           vld_d, vld_q;
  phr_pkg::spread_t               spread_d, spread_q;
  logic [phr_pkg::ChanW-1:0]      hi_rg, lo_rg, diff;

  assign rdy_o = !vld_q || next_rdy_i;

  always_comb begin
    hi_rg         = (pix_i.red > pix_i.green) ? pix_i.red : pix_i.green;
    lo_rg         = (pix_i.red < pix_i.green) ? pix_i.red : pix_i.green;
    spread_d.hi   = (hi_rg > pix_i.blue) ? hi_rg : pix_i.blue;
    spread_d.lo   = (lo_rg < pix_i.blue) ? lo_rg : pix_i.blue;
    diff          = spread_d.hi - spread_d.lo;
    spread_d.prod = phr_pkg::ProdW'(diff) * phr_pkg::ProdW'(k_i);
  end

  assign vld_d = rdy_o ? valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy_o) begin
      spread_q <= spread_d;
    end
  end

  assign valid_o  = vld_q;
  assign spread_o = spread_q;

endmodule

@@ rtl/core/phr_scale.sv @@
module phr_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  phr_pkg::spread_t    spread_i,
  input  logic                next_rdy_i,
  output logic                rdy_o,
  output logic                valid_o,
  output phr_pkg::level_t     level_o
);

  logic                           vld_d, vld_q;
  phr_pkg::level_t                level_d, level_q;
  logic [phr_pkg::ScaledW-1:0]    scaled;

  assign rdy_o = !vld_q || next_rdy_i;

  // Divide by 60 through the reciprocal; exact over the whole product range
  always_comb begin
    scaled     = phr_pkg::ScaledW'(spread_i.prod) * phr_pkg::RecipMul;
    level_d.hi = spread_i.hi;
    level_d.lo = spread_i.lo;
    level_d.m  = scaled[phr_pkg::RecipShift +: phr_pkg::ChanW];
  end

  assign vld_d = rdy_o ? valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy_o) begin
      level_q <= level_d;
    end
  end

  assign valid_o = vld_q;
  assign level_o = level_q;

endmodule

@@ rtl/core/phr_assemble.sv @@
module phr_assemble (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  phr_pkg::level_t     level_i,
  input  phr_pkg::sector_e    sector_i,
  input  logic                stall_i,
  output logic                rdy_o,
  output logic                valid_o,
  output phr_pkg::pixel_t     pix_o
);

  logic                           vld_d, vld_q;
  phr_pkg::pixel_t                pix_d, pix_q;
  logic [phr_pkg::ChanW-1:0]      up, down;

  assign rdy_o = !vld_q || !stall_i;

  // A gray pixel has hi == lo and m == 0, so every arm returns it unchanged
  always_comb begin
    up   = level_i.lo + level_i.m;
    down = level_i.hi - level_i.m;
    case (sector_i)
      phr_pkg::SECT_RY: pix_d = '{red: level_i.hi, green: up,         blue: level_i.lo};
      phr_pkg::SECT_YG: pix_d = '{red: down,       green: level_i.hi, blue: level_i.lo};
      phr_pkg::SECT_GC: pix_d = '{red: level_i.lo, green: level_i.hi, blue: up};
      phr_pkg::SECT_CB: pix_d = '{red: level_i.lo, green: down,       blue: level_i.hi};
      phr_pkg::SECT_BM: pix_d = '{red: up,         green: level_i.lo, blue: level_i.hi};
      default:          pix_d = '{red: level_i.hi, green: level_i.lo, blue: down};
    endcase
  end

  assign vld_d = rdy_o ? valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy_o) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = vld_q;
  assign pix_o   = pix_q;

endmodule

@@ rtl/core/pixel_hue_replace.sv @@
// Hue replacement for 8-bit RGB pixels: every word leaves with the hue set by
// cfg_wdata_i (whole degrees, 360..511 wrap once) while its HSV saturation and
// value are kept; gray pixels pass unchanged. The block takes one pixel per
// clock while in_stall_o is low and passes it through three pipeline registers:
// min/max and the d*k product, the reciprocal multiply for the divide by 60,
// and the sector mux into the output register. in_stall_o rises only when all
// three stages are full and out_stall_i holds the output word. Write the hue
// only while no pixel is in flight; it is decoded to sector and offset at the
// write and takes effect for the next pixel accepted.
module pixel_hue_replace (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [phr_pkg::HueW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [phr_pkg::ChanW-1:0]  red_in_i,
  input  logic [phr_pkg::ChanW-1:0]  green_in_i,
  input  logic [phr_pkg::ChanW-1:0]  blue_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [phr_pkg::ChanW-1:0]  red_out_o,
  output logic [phr_pkg::ChanW-1:0]  green_out_o,
  output logic [phr_pkg::ChanW-1:0]  blue_out_o
);

  phr_pkg::hue_t      hue;
  phr_pkg::pixel_t    pix_in, pix_out;
  phr_pkg::spread_t   spread;
  phr_pkg::level_t    level;
  logic               spread_rdy, spread_vld;
  logic               scale_rdy, scale_vld;
  logic               asm_rdy;

  assign pix_in = '{red: red_in_i, green: green_in_i, blue: blue_in_i};

  // Hold the decoded hue
  phr_hue_cfg u_hue_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .hue_o       (hue)
  );

  // Stage 1: extremes of the pixel and d * k
  phr_spread u_spread (
    .clk_i,
    .rst_ni,
    .valid_i    (in_valid_i),
    .pix_i      (pix_in),
    .k_i        (hue.k),
    .next_rdy_i (scale_rdy),
    .rdy_o      (spread_rdy),
    .valid_o    (spread_vld),
    .spread_o   (spread)
  );

  // Stage 2: m = floor(d * k / 60)
  phr_scale u_scale (
    .clk_i,
    .rst_ni,
    .valid_i    (spread_vld),
    .spread_i   (spread),
    .next_rdy_i (asm_rdy),
    .rdy_o      (scale_rdy),
    .valid_o    (scale_vld),
    .level_o    (level)
  );

  // Stage 3: place hi, lo, up and down by sector; output register
  phr_assemble u_assemble (
    .clk_i,
    .rst_ni,
    .valid_i  (scale_vld),
    .level_i  (level),
    .sector_i (hue.sector),
    .stall_i  (out_stall_i),
    .rdy_o    (asm_rdy),
    .valid_o  (out_valid_o),
    .pix_o    (pix_out)
  );

  assign in_stall_o  = !spread_rdy;
  assign red_out_o   = pix_out.red;
  assign green_out_o = pix_out.green;
  assign blue_out_o  = pix_out.blue;

endmodule

@@ rtl/core/phr_checker.sv @@
module phr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [phr_pkg::ChanW-1:0]  red_out_o,
  input logic [phr_pkg::ChanW-1:0]  green_out_o,
  input logic [phr_pkg::ChanW-1:0]  blue_out_o
);

  // Hold a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_out_o) && $stable(green_out_o)
                                   && $stable(blue_out_o))
    else $error("stalled output word changed");

  // Input backpressure only comes from a held output word
  assert property (@(posedge clk_i)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // An accepted pixel reaches the output when the sink keeps taking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("pixel lost in pipeline");

endmodule

bind pixel_hue_replace phr_checker u_phr_checker (.*);
